### rtl/skis_pkg.sv
// shared types and constants for the sorted key interval search block
// used by skis_cell, skis_chain and sorted_key_interval_search
package skis_pkg;

   localparam int TAG_BITS = 8;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_QUERY  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_RESPOND
   } state_type;

   // broadcast strobes from the controller to every cell
   typedef struct packed {
      logic clear;
      logic insert;
      logic query;
   } cell_ctl_type;

   // one query hit flag plus the tag of the hit cell (zero elsewhere)
   typedef struct packed {
      logic                hit;
      logic [TAG_BITS-1:0] tag;
   } match_type;

endpackage

### rtl/sorted_key_interval_search.sv
// top level of the sorted key interval search block: controller, cell chain and result tree
// depends on skis_pkg, skis_chain and skis_or_tree
//
// requests arrive on req_ (tuser = request kind, tdata = key) and every request
// gives exactly one beat on rsp_ (tuser = status, tdata = found index).
// clear empties the table, insert places the key in sorted position behind any
// equal keys and tags it with its arrival count since the last clear, query returns
// the tag of the last entry whose key is at or below the request key.
// one request is handled at a time: clear and insert update every cell of the chain
// in the accept cycle and their result is offered on the next cycle; a query latches
// the one-hot match of the cells into their leaf registers and folds it through a
// registered radix-16 or-tree; the result is offered once the tree root holds it.
// a new request is taken only once the result beat has gone, so requests never overlap.
// a stalled receiver holds the result beat stable and req_tready low.
// synchronous reset empties the table, clears the arrival count and returns to idle.
module sorted_key_interval_search #(
   parameter int DEPTH    = 256,
   parameter int KEY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] found_index
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int LEVELS  = ($clog2(DEPTH) + 3) / 4;
   localparam int CNT_W   = $clog2(LEVELS) + 1;
   localparam int MATCH_W = $bits(skis_pkg::match_type);

   skis_pkg::state_type           state_ff, state_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic [skis_pkg::TAG_BITS-1:0] arrival_ff, arrival_in;
   logic [CNT_W-1:0]              search_cnt_ff, search_cnt_in;
   logic                          query_ff, query_in;
   skis_pkg::status_type          status_ff, status_in;

   skis_pkg::cell_ctl_type        ctl;
   skis_pkg::req_kind_type        kind;
   logic [KEY_BITS-1:0]           key;
   logic                          full;
   logic [MATCH_W-1:0]            leaf [DEPTH];
   logic [MATCH_W-1:0]            root_bits;
   skis_pkg::match_type           root;

   assign kind     = skis_pkg::req_kind_type'(req_tuser);
   assign key      = KEY_BITS'(req_tdata);
   assign full     = (count_ff == COUNT_W'(DEPTH));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      arrival_in    = arrival_ff;
      search_cnt_in = search_cnt_ff;
      query_in      = query_ff;
      status_in     = status_ff;
      ctl           = '0;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      case (state_ff)
         skis_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               query_in  = 1'b0;
               status_in = skis_pkg::ST_OK;
               state_in  = skis_pkg::S_RESPOND;
               case (kind)
                  skis_pkg::REQ_CLEAR: begin
                     ctl.clear  = 1'b1;
                     count_in   = '0;
                     arrival_in = '0;
                  end
                  skis_pkg::REQ_INSERT: begin
                     if (full) begin
                        status_in = skis_pkg::ST_FULL;
                     end else begin
                        ctl.insert = 1'b1;
                        count_in   = count_ff + COUNT_W'(1);
                        arrival_in = arrival_ff + skis_pkg::TAG_BITS'(1);
                     end
                  end
                  skis_pkg::REQ_QUERY: begin
                     ctl.query     = 1'b1;
                     query_in      = 1'b1;
                     search_cnt_in = '0;
                     state_in      = skis_pkg::S_SEARCH;
                  end
                  default: begin
                     // unused kind: plain ok beat
                  end
               endcase
            end
         end
         skis_pkg::S_SEARCH: begin
            search_cnt_in = search_cnt_ff + CNT_W'(1);
            if (search_cnt_ff == CNT_W'(LEVELS - 1)) begin
               state_in = skis_pkg::S_RESPOND;
            end
         end
         skis_pkg::S_RESPOND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = skis_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = skis_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= skis_pkg::S_IDLE;
         count_ff      <= '0;
         arrival_ff    <= '0;
         search_cnt_ff <= '0;
         query_ff      <= 1'b0;
         status_ff     <= skis_pkg::ST_OK;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         arrival_ff    <= arrival_in;
         search_cnt_ff <= search_cnt_in;
         query_ff      <= query_in;
         status_ff     <= status_in;
      end
   end

   skis_chain #(
      .DEPTH   (DEPTH),
      .KEY_BITS(KEY_BITS)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .new_key(key),
      .new_tag(arrival_ff),
      .leaf   (leaf)
   );

   skis_or_tree #(
      .WIDTH (MATCH_W),
      .LEAVES(DEPTH)
   ) u_tree (
      .clock(clock),
      .leaf (leaf),
      .root (root_bits)
   );

   assign root = skis_pkg::match_type'(root_bits);

   // the tree root holds steady while the query beat waits, the cells are idle
   always_comb begin
      if (query_ff) begin
         rsp_tuser = root.hit ? skis_pkg::ST_OK : skis_pkg::ST_MISS;
         rsp_tdata = root.tag;
      end else begin
         rsp_tuser = status_ff;
         rsp_tdata = '0;
      end
   end

endmodule

### rtl/skis_cell.sv
// one cell of the sorted chain: holds a key, its tag and a valid flag
// depends on skis_pkg
module skis_cell #(
   parameter int KEY_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  skis_pkg::cell_ctl_type          ctl,
   input  logic [KEY_BITS-1:0]             new_key,
   input  logic [skis_pkg::TAG_BITS-1:0]   new_tag,
   input  logic [KEY_BITS-1:0]             prev_key,
   input  logic [skis_pkg::TAG_BITS-1:0]   prev_tag,
   input  logic                            prev_le,
   input  logic                            prev_valid,
   input  logic                            next_le,
   output logic [KEY_BITS-1:0]             key_q,
   output logic [skis_pkg::TAG_BITS-1:0]   tag_q,
   output logic                            valid_q,
   output logic                            le_out,
   output skis_pkg::match_type             leaf_q
);

   logic [KEY_BITS-1:0]           key_ff, key_in;
   logic [skis_pkg::TAG_BITS-1:0] tag_ff, tag_in;
   logic                          valid_ff, valid_in;
   skis_pkg::match_type           leaf_ff, leaf_in;
   logic                          le;
   logic                          match;

   assign le    = valid_ff && (key_ff <= new_key);
   // last valid cell at or below the key: its successor is above the key or empty
   assign match = le && !next_le;

   always_comb begin
      key_in   = key_ff;
      tag_in   = tag_ff;
      valid_in = valid_ff;
      leaf_in  = leaf_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         valid_in = valid_ff || prev_valid;
         if (!le) begin
            if (prev_le) begin
               key_in = new_key;
               tag_in = new_tag;
            end else begin
               key_in = prev_key;
               tag_in = prev_tag;
            end
         end
      end else if (ctl.query) begin
         leaf_in.hit = match;
         leaf_in.tag = match ? tag_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      tag_ff  <= tag_in;
      leaf_ff <= leaf_in;
   end

   assign key_q   = key_ff;
   assign tag_q   = tag_ff;
   assign valid_q = valid_ff;
   assign le_out  = le;
   assign leaf_q  = leaf_ff;

endmodule

### rtl/skis_chain.sv
// row of skis_cell instances wired to their neighbours
// depends on skis_pkg and skis_cell
module skis_chain #(
   parameter int DEPTH    = 256,
   parameter int KEY_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  skis_pkg::cell_ctl_type          ctl,
   input  logic [KEY_BITS-1:0]             new_key,
   input  logic [skis_pkg::TAG_BITS-1:0]   new_tag,
   output logic [$bits(skis_pkg::match_type)-1:0] leaf [DEPTH]
);

   logic [KEY_BITS-1:0]           key_q   [DEPTH];
   logic [skis_pkg::TAG_BITS-1:0] tag_q   [DEPTH];
   logic                          valid_q [DEPTH];
   logic                          le      [DEPTH];
   skis_pkg::match_type           leaf_q  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0]           p_key;
      logic [skis_pkg::TAG_BITS-1:0] p_tag;
      logic                          p_le;
      logic                          p_valid;
      logic                          n_le;

      if (i == 0) begin : g_head
         // head cell: everything to its left counts as at or below the key
         assign p_key   = new_key;
         assign p_tag   = new_tag;
         assign p_le    = 1'b1;
         assign p_valid = 1'b1;
      end else begin : g_body
         assign p_key   = key_q[i-1];
         assign p_tag   = tag_q[i-1];
         assign p_le    = le[i-1];
         assign p_valid = valid_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign n_le = 1'b0;
      end else begin : g_mid
         assign n_le = le[i+1];
      end

      skis_cell #(
         .KEY_BITS(KEY_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_key   (new_key),
         .new_tag   (new_tag),
         .prev_key  (p_key),
         .prev_tag  (p_tag),
         .prev_le   (p_le),
         .prev_valid(p_valid),
         .next_le   (n_le),
         .key_q     (key_q[i]),
         .tag_q     (tag_q[i]),
         .valid_q   (valid_q[i]),
         .le_out    (le[i]),
         .leaf_q    (leaf_q[i])
      );

      assign leaf[i] = leaf_q[i];
   end

endmodule

### rtl/skis_or_tree.sv
// registered radix-16 or-reduction tree over the cell query outputs
// stand-alone, no package dependency
module skis_or_tree #(
   parameter int WIDTH  = 9,
   parameter int LEAVES = 256
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);

   localparam int LEVELS = ($clog2(LEAVES) + 3) / 4;
   localparam int PAD    = 1 << (4 * LEVELS);

   logic [WIDTH-1:0] stage   [0:LEVELS][PAD];
   logic [WIDTH-1:0] node_in [1:LEVELS][PAD];
   logic [WIDTH-1:0] node_ff [1:LEVELS][PAD];

   for (genvar j = 0; j < PAD; j++) begin : g_pad
      if (j < LEAVES) begin : g_leaf
         assign stage[0][j] = leaf[j];
      end else begin : g_zero
         assign stage[0][j] = '0;
      end
   end

   for (genvar l = 1; l <= LEVELS; l++) begin : g_level
      for (genvar j = 0; j < PAD; j++) begin : g_node
         if (j < (PAD >> (4 * l))) begin : g_live
            always_comb begin
               node_in[l][j] = '0;
               for (int c = 0; c < 16; c++) begin
                  node_in[l][j] = node_in[l][j] | stage[l-1][16*j + c];
               end
            end
         end else begin : g_idle
            assign node_in[l][j] = '0;
         end

         always_ff @(posedge clock) begin
            node_ff[l][j] <= node_in[l][j];
         end

         assign stage[l][j] = node_ff[l][j];
      end
   end

   assign root = stage[LEVELS][0];

endmodule
